FILE: rtl/rfsr_pkg.sv
// package: types, codes and helpers for the radio fault state resolver
`timescale 1ns / 1ps

package rfsr_pkg;

	localparam int MAX_PORTS = 8;
	localparam int PORT_W = 8;
	localparam int CNT_W = 4;
	localparam int TIMEOUT_W = 16;
	localparam int TIME_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_SERVICE = 2'd0,
		OP_TX_ON   = 2'd1,
		OP_TX_OFF  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_INITIAL  = 3'd0,
		ST_NORMAL   = 3'd1,
		ST_STANDBY  = 3'd2,
		ST_DOWNLOAD = 3'd3,
		ST_LINKFAIL = 3'd4,
		ST_DEGRADED = 3'd5,
		ST_FAILED   = 3'd6
	} radio_st_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TX_PORTS   = 2'd0,
		CFG_RX_PORTS   = 2'd1,
		CFG_HB_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0]     tx_ports_in_use;
		logic [CNT_W-1:0]     rx_ports_in_use;
		logic [TIMEOUT_W-1:0] heartbeat_timeout_s;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [2:0]        port;
		logic [PORT_W-1:0] tx_shutdown_alarms;
		logic [PORT_W-1:0] tx_degraded_alarms;
		logic [PORT_W-1:0] vswr_alarms;
		logic [PORT_W-1:0] rx_major_alarms;
		logic              heartbeat_alarm;
		logic              radio_temp_major_alarm;
		logic              link_major_alarm;
		logic              downloading;
		logic [TIME_W-1:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic [2:0]        radio_state;
		logic              state_changed;
		logic [PORT_W-1:0] shutdown_request_mask;
		logic [PORT_W-1:0] shutdown_done_mask;
		logic [PORT_W-1:0] clear_path_mask;
		logic              clear_common_alarms;
		logic              reboot_request;
	} result_t;

	typedef struct packed {
		logic [PORT_W-1:0] tx_on_flags;
		logic              tx_on_updated;
		radio_st_t         current_state;
		logic [PORT_W-1:0] shutdown_cache;
		logic              hb_running;
		logic [TIME_W-1:0] hb_start;
	} rstate_t;

	function automatic logic [PORT_W-1:0] port_mask(input logic [CNT_W-1:0] count);
		logic [PORT_W-1:0] m;
		for (int i = 0; i < PORT_W; i++) begin
			m[i] = (i < int'(count)) && (i < MAX_PORTS);
		end
		return m;
	endfunction

endpackage

FILE: rtl/rfsr_if.sv
// interfaces: request channel in and result channel out
`timescale 1ns / 1ps

interface rfsr_in_if;
	import rfsr_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        op;
	logic [2:0]        port;
	logic [PORT_W-1:0] tx_shutdown_alarms;
	logic [PORT_W-1:0] tx_degraded_alarms;
	logic [PORT_W-1:0] vswr_alarms;
	logic [PORT_W-1:0] rx_major_alarms;
	logic              heartbeat_alarm;
	logic              radio_temp_major_alarm;
	logic              link_major_alarm;
	logic              downloading;
	logic [TIME_W-1:0] now_seconds;

	modport source (
		output valid, op, port, tx_shutdown_alarms, tx_degraded_alarms, vswr_alarms,
		       rx_major_alarms, heartbeat_alarm, radio_temp_major_alarm,
		       link_major_alarm, downloading, now_seconds,
		input  ready
	);
	modport sink (
		input  valid, op, port, tx_shutdown_alarms, tx_degraded_alarms, vswr_alarms,
		       rx_major_alarms, heartbeat_alarm, radio_temp_major_alarm,
		       link_major_alarm, downloading, now_seconds,
		output ready
	);
endinterface

interface rfsr_out_if;
	import rfsr_pkg::*;
	logic              valid;
	logic              ready;
	logic [2:0]        radio_state;
	logic              state_changed;
	logic [PORT_W-1:0] shutdown_request_mask;
	logic [PORT_W-1:0] shutdown_done_mask;
	logic [PORT_W-1:0] clear_path_mask;
	logic              clear_common_alarms;
	logic              reboot_request;

	modport source (
		output valid, radio_state, state_changed, shutdown_request_mask,
		       shutdown_done_mask, clear_path_mask, clear_common_alarms, reboot_request,
		input  ready
	);
	modport sink (
		input  valid, radio_state, state_changed, shutdown_request_mask,
		       shutdown_done_mask, clear_path_mask, clear_common_alarms, reboot_request,
		output ready
	);
endinterface

FILE: rtl/rfsr_cfg.sv
// configuration registers with write port
`timescale 1ns / 1ps

module rfsr_cfg
	import rfsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_ports_in_use     <= CNT_W'(2);
			cfg_q.rx_ports_in_use     <= CNT_W'(2);
			cfg_q.heartbeat_timeout_s <= TIMEOUT_W'(60);
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_TX_PORTS:   cfg_q.tx_ports_in_use     <= wr_data[CNT_W-1:0];
				CFG_RX_PORTS:   cfg_q.rx_ports_in_use     <= wr_data[CNT_W-1:0];
				CFG_HB_TIMEOUT: cfg_q.heartbeat_timeout_s <= wr_data[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/rfsr_resolve.sv
// single-pass resolve: event flag update or service pass with state priority
`timescale 1ns / 1ps

module rfsr_resolve
	import rfsr_pkg::*;
(
	input  item_t   item,
	input  cfg_t    cfg,
	input  rstate_t cur,
	output rstate_t nxt,
	output logic    has_result,
	output result_t res
);

	logic [PORT_W-1:0] txm, rxm, port_bit, clr, cache_a, sd, dg, vs, rx, fault, req;
	logic              ev_valid, clr_common, hb, temp, link, changed, reboot;
	radio_st_t         st;
	logic [TIME_W-1:0] elapsed;

	always_comb begin
		txm = port_mask(cfg.tx_ports_in_use);
		rxm = port_mask(cfg.rx_ports_in_use);
		for (int i = 0; i < PORT_W; i++) begin
			port_bit[i] = (int'(item.port) == i);
		end
		ev_valid = ({1'b0, item.port} < cfg.tx_ports_in_use) && (int'(item.port) < MAX_PORTS);

		// service pass: if any port was switched on since the last pass, clear every port now on
		clr        = cur.tx_on_updated ? (cur.tx_on_flags & txm) : '0;
		clr_common = |clr;
		cache_a    = cur.shutdown_cache & ~clr;

		sd   = item.tx_shutdown_alarms & ~clr;
		dg   = item.tx_degraded_alarms & ~clr;
		vs   = item.vswr_alarms & ~clr;
		rx   = item.rx_major_alarms & ~clr;
		hb   = item.heartbeat_alarm && !clr_common;
		temp = item.radio_temp_major_alarm && !clr_common;
		link = item.link_major_alarm && !clr_common;

		fault = (sd | vs) & txm;
		req   = '0;
		priority if (item.downloading) begin
			st = ST_DOWNLOAD;
		end else if (hb || temp || (fault == txm) || ((rx & rxm) == rxm)) begin
			st  = ST_FAILED;
			req = txm;
		end else if (link) begin
			st = ST_LINKFAIL;
		end else if (|fault) begin
			st  = ST_DEGRADED;
			req = fault;
		end else if ((|(rx & rxm)) || (|(dg & txm))) begin
			st = ST_DEGRADED;
		end else if (|(cur.tx_on_flags & txm)) begin
			st = ST_NORMAL;
		end else begin
			st = ST_STANDBY;
		end

		elapsed = item.now_seconds - cur.hb_start;
		reboot  = hb && cur.hb_running &&
		          (elapsed > {{(TIME_W-TIMEOUT_W){1'b0}}, cfg.heartbeat_timeout_s});
		changed = (st != cur.current_state) || (req != (cache_a & txm));

		nxt        = cur;
		has_result = 1'b0;
		res        = '0;
		unique case (op_t'(item.op))
			OP_TX_ON: begin
				nxt.tx_on_updated = 1'b1;
				if (ev_valid) nxt.tx_on_flags = cur.tx_on_flags | port_bit;
			end
			OP_TX_OFF: begin
				if (ev_valid) nxt.tx_on_flags = cur.tx_on_flags & ~port_bit;
			end
			OP_SERVICE: begin
				has_result        = 1'b1;
				nxt.tx_on_updated = 1'b0;
				nxt.shutdown_cache = cache_a;
				if (hb) begin
					if (!cur.hb_running) begin
						nxt.hb_running = 1'b1;
						nxt.hb_start   = item.now_seconds;
					end
				end else if (cur.hb_running) begin
					nxt.hb_running = 1'b0;
					nxt.hb_start   = '0;
				end
				if (changed) begin
					if (st == ST_FAILED) nxt.shutdown_cache = cache_a | txm;
					else if (st == ST_DEGRADED) nxt.shutdown_cache = cache_a | req;
					nxt.current_state = st;
				end
				res.radio_state           = st;
				res.state_changed         = changed;
				res.shutdown_request_mask = req;
				res.shutdown_done_mask    = nxt.shutdown_cache & txm;
				res.clear_path_mask       = clr;
				res.clear_common_alarms   = clr_common;
				res.reboot_request        = reboot;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/radio_fault_state_resolver_top.sv
// top level: input register, resolve logic, state and result register
//
// channel  dir  role    contents
// item     in   sink    op, port, alarm bits, now_seconds
// result   out  source  radio_state, masks, change, clear and reboot flags
// wr_*     in   write   configuration register index and data
//
// one request accepted per cycle while no result is held; the accepting edge
// loads the input register; the result register loads when the output advances
// events update the port flags and give no result
// a held result stalls the input register; one further request is still taken
// asynchronous reset clears state and both valid bits and restores the default configuration
`timescale 1ns / 1ps

module radio_fault_state_resolver_top
	import rfsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rfsr_in_if.sink               item,
	rfsr_out_if.source            result,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	rstate_t state_q, state_nxt;
	logic    has_result;
	result_t res_nxt;
	logic    advance, fire;

	rfsr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rfsr_resolve u_resolve (
		.item       (item_s1),
		.cfg        (cfg),
		.cur        (state_q),
		.nxt        (state_nxt),
		.has_result (has_result),
		.res        (res_nxt)
	);

	assign advance    = !valid_s2 || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{tx_on_flags: '0, tx_on_updated: 1'b0, current_state: ST_INITIAL,
			              shutdown_cache: '0, hb_running: 1'b0, hb_start: '0};
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (advance) valid_s2 <= fire && has_result;
			if (fire) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op                     <= item.op;
			item_s1.port                   <= item.port;
			item_s1.tx_shutdown_alarms     <= item.tx_shutdown_alarms;
			item_s1.tx_degraded_alarms     <= item.tx_degraded_alarms;
			item_s1.vswr_alarms            <= item.vswr_alarms;
			item_s1.rx_major_alarms        <= item.rx_major_alarms;
			item_s1.heartbeat_alarm        <= item.heartbeat_alarm;
			item_s1.radio_temp_major_alarm <= item.radio_temp_major_alarm;
			item_s1.link_major_alarm       <= item.link_major_alarm;
			item_s1.downloading            <= item.downloading;
			item_s1.now_seconds            <= item.now_seconds;
		end
		if (fire && has_result) res_s2 <= res_nxt;
	end

	assign result.valid                 = valid_s2;
	assign result.radio_state           = res_s2.radio_state;
	assign result.state_changed         = res_s2.state_changed;
	assign result.shutdown_request_mask = res_s2.shutdown_request_mask;
	assign result.shutdown_done_mask    = res_s2.shutdown_done_mask;
	assign result.clear_path_mask       = res_s2.clear_path_mask;
	assign result.clear_common_alarms   = res_s2.clear_common_alarms;
	assign result.reboot_request        = res_s2.reboot_request;

endmodule

FILE: rtl/rfsr_checker.sv
// checker on the top level result port, with bind
`timescale 1ns / 1ps

module rfsr_checker
	import rfsr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [2:0]        radio_state,
	input logic [PORT_W-1:0] shutdown_request_mask,
	input logic [PORT_W-1:0] shutdown_done_mask,
	input logic [PORT_W-1:0] clear_path_mask,
	input logic              clear_common_alarms,
	input logic              reboot_request
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (shutdown_request_mask & ~shutdown_done_mask) == '0)
		else $error("requested path not in shutdown cache");

	a_req_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (shutdown_request_mask != '0) |->
			(radio_state == ST_FAILED) || (radio_state == ST_DEGRADED))
		else $error("shutdown request outside failed or degraded");

	a_clr_common: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (clear_common_alarms == (clear_path_mask != '0)))
		else $error("common clear does not follow path clear");

	a_reboot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && reboot_request |->
			(radio_state == ST_FAILED) || (radio_state == ST_DOWNLOAD))
		else $error("reboot request in wrong state");

endmodule

bind radio_fault_state_resolver_top rfsr_checker u_rfsr_checker (
	.clk                   (clk),
	.arst_n                (arst_n),
	.res_valid             (result.valid),
	.res_ready             (result.ready),
	.radio_state           (result.radio_state),
	.shutdown_request_mask (result.shutdown_request_mask),
	.shutdown_done_mask    (result.shutdown_done_mask),
	.clear_path_mask       (result.clear_path_mask),
	.clear_common_alarms   (result.clear_common_alarms),
	.reboot_request        (result.reboot_request)
);

FILE: tb/sv/tb_radio_fault_state_resolver_top.sv
// testbench for the radio fault state resolver: directed table, then checked random requests
`timescale 1ns / 1ps

module tb_radio_fault_state_resolver_top;
	import rfsr_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		item_t   req;
		bit      known;
		result_t want;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	rfsr_in_if  item_ch();
	rfsr_out_if res_ch();

	radio_fault_state_resolver_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_ch),
		.result   (res_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #6 clk = ~clk;

	// predictor state and its copy of the registers
	logic [CNT_W-1:0]     cfg_tx = 4'd2;
	logic [CNT_W-1:0]     cfg_rx = 4'd2;
	logic [TIMEOUT_W-1:0] cfg_hb_to = 16'd60;
	logic [PORT_W-1:0]    on_flags = '0;
	logic                 on_pending = 1'b0;
	radio_st_t            held_state = ST_INITIAL;
	logic [PORT_W-1:0]    off_cache = '0;
	logic                 hb_armed = 1'b0;
	logic [TIME_W-1:0]    hb_since = '0;

	result_t status_due[$];
	int      fails = 0;
	bit      tx_idle = 1'b1;
	bit      rx_idle = 1'b1;
	logic [TIME_W-1:0] t_now = '0;
	logic              hb_hold = 1'b0;

	function automatic logic [PORT_W-1:0] lane_mask(input logic [CNT_W-1:0] n);
		if (n >= 4'd8)
			return 8'hFF;
		return 8'hFF >> (4'd8 - n);
	endfunction

	function automatic void resolve_request(input item_t rq, output bit emits,
		output result_t res);
		logic [PORT_W-1:0] txm, rxm, cleared, sd, dg, vs, rx, fault, req;
		logic              wipe, hb, tp, lk, boot, chg;
		logic [TIME_W-1:0] elapsed;
		radio_st_t         st;
		emits = 1'b0;
		res = '0;
		txm = lane_mask(cfg_tx);
		rxm = lane_mask(cfg_rx);
		if (rq.op == OP_TX_ON || rq.op == OP_TX_OFF) begin
			if (rq.op == OP_TX_ON)
				on_pending = 1'b1;
			if ({1'b0, rq.port} < cfg_tx)
				on_flags[rq.port] = (rq.op == OP_TX_ON);
			return;
		end
		if (rq.op != OP_SERVICE)
			return;

		// after any switch-on since the last pass, every port now on gets its alarms cleared
		cleared = '0;
		wipe = 1'b0;
		if (on_pending) begin
			cleared = on_flags & txm;
			wipe = |cleared;
			off_cache &= ~cleared;
			on_pending = 1'b0;
		end
		sd = rq.tx_shutdown_alarms & ~cleared;
		dg = rq.tx_degraded_alarms & ~cleared;
		vs = rq.vswr_alarms & ~cleared;
		rx = rq.rx_major_alarms & ~cleared;
		hb = rq.heartbeat_alarm & ~wipe;
		tp = rq.radio_temp_major_alarm & ~wipe;
		lk = rq.link_major_alarm & ~wipe;

		fault = (sd | vs) & txm;
		req = '0;
		if (rq.downloading)
			st = ST_DOWNLOAD;
		else if (hb || tp || fault == txm || (rx & rxm) == rxm) begin
			st = ST_FAILED;
			req = txm;
		end else if (lk)
			st = ST_LINKFAIL;
		else if (fault != '0) begin
			st = ST_DEGRADED;
			req = fault;
		end else if ((rx & rxm) != '0 || (dg & txm) != '0)
			st = ST_DEGRADED;
		else if ((on_flags & txm) != '0)
			st = ST_NORMAL;
		else
			st = ST_STANDBY;

		boot = 1'b0;
		if (hb) begin
			if (!hb_armed) begin
				hb_armed = 1'b1;
				hb_since = rq.now_seconds;
			end else begin
				elapsed = rq.now_seconds - hb_since;
				boot = elapsed > {16'h0, cfg_hb_to};
			end
		end else if (hb_armed) begin
			hb_armed = 1'b0;
			hb_since = '0;
		end

		chg = (st != held_state) || (req != (off_cache & txm));
		if (chg) begin
			if (st == ST_FAILED)
				off_cache |= txm;
			else if (st == ST_DEGRADED)
				off_cache |= req;
			held_state = st;
		end

		emits = 1'b1;
		res.radio_state = st;
		res.state_changed = chg;
		res.shutdown_request_mask = req;
		res.shutdown_done_mask = off_cache & txm;
		res.clear_path_mask = cleared;
		res.clear_common_alarms = wipe;
		res.reboot_request = boot;
	endfunction

	function automatic item_t pack_req(input logic [1:0] op, input logic [2:0] port,
		input logic [7:0] sd, input logic [7:0] dg, input logic [7:0] vs,
		input logic [7:0] rx, input logic hb, input logic tp, input logic lk,
		input logic dl, input logic [31:0] now);
		item_t r;
		r.op = op;
		r.port = port;
		r.tx_shutdown_alarms = sd;
		r.tx_degraded_alarms = dg;
		r.vswr_alarms = vs;
		r.rx_major_alarms = rx;
		r.heartbeat_alarm = hb;
		r.radio_temp_major_alarm = tp;
		r.link_major_alarm = lk;
		r.downloading = dl;
		r.now_seconds = now;
		return r;
	endfunction

	function automatic result_t status(input radio_st_t st, input logic chg,
		input logic [7:0] req, input logic [7:0] done, input logic [7:0] clr,
		input logic cc, input logic rb);
		result_t r;
		r.radio_state = st;
		r.state_changed = chg;
		r.shutdown_request_mask = req;
		r.shutdown_done_mask = done;
		r.clear_path_mask = clr;
		r.clear_common_alarms = cc;
		r.reboot_request = rb;
		return r;
	endfunction

	function automatic logic [7:0] draw_lanes();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'h00;
			5, 6, 7: return (8'h01 << $urandom_range(0, 7)) |
				($urandom_range(0, 1) ? (8'h01 << $urandom_range(0, 7)) : 8'h00);
			8: return 8'($urandom());
			default: return 8'hFF;
		endcase
	endfunction

	// mostly service passes and on/off events on present ports, some noise
	function automatic item_t draw_request();
		item_t r;
		int    pick;
		bit    quiet;
		pick = $urandom_range(0, 9);
		quiet = $urandom_range(0, 9) < 4;
		if (pick <= 4)
			r.op = OP_SERVICE;
		else if (pick <= 7)
			r.op = OP_TX_ON;
		else if (pick == 8)
			r.op = OP_TX_OFF;
		else
			r.op = $urandom_range(0, 1) ? OP_UNUSED : OP_TX_OFF;
		if ($urandom_range(0, 3) == 0 || cfg_tx == '0)
			r.port = 3'($urandom_range(0, 7));
		else
			r.port = 3'($urandom_range(0, (cfg_tx > 4'd8 ? 8 : int'(cfg_tx)) - 1));
		r.tx_shutdown_alarms = quiet ? 8'h00 : draw_lanes();
		r.tx_degraded_alarms = quiet ? 8'h00 : draw_lanes();
		r.vswr_alarms = quiet ? 8'h00 : draw_lanes();
		r.rx_major_alarms = quiet ? 8'h00 : draw_lanes();
		if ($urandom_range(0, 11) == 0)
			hb_hold = ~hb_hold;
		r.heartbeat_alarm = hb_hold;
		r.radio_temp_major_alarm = !quiet && $urandom_range(0, 11) == 0;
		r.link_major_alarm = !quiet && $urandom_range(0, 7) == 0;
		r.downloading = $urandom_range(0, 11) == 0;
		case ($urandom_range(0, 19))
			0: t_now = $urandom();
			1, 2: t_now += 32'($urandom_range(0, 2 * int'(cfg_hb_to) + 2));
			default: t_now += 32'($urandom_range(0, 3));
		endcase
		r.now_seconds = t_now;
		return r;
	endfunction

	task automatic offer(input item_t rq, input bit drain, input bit known,
		input result_t want);
		int      gap;
		bit      hold;
		bit      emits;
		result_t res;
		gap = tx_idle ? $urandom_range(0, 12) : 0;
		hold = drain && status_due.size() != 0;
		if (gap != 0 || hold) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			while (hold && status_due.size() != 0)
				@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= rq.op;
		item_ch.port <= rq.port;
		item_ch.tx_shutdown_alarms <= rq.tx_shutdown_alarms;
		item_ch.tx_degraded_alarms <= rq.tx_degraded_alarms;
		item_ch.vswr_alarms <= rq.vswr_alarms;
		item_ch.rx_major_alarms <= rq.rx_major_alarms;
		item_ch.heartbeat_alarm <= rq.heartbeat_alarm;
		item_ch.radio_temp_major_alarm <= rq.radio_temp_major_alarm;
		item_ch.link_major_alarm <= rq.link_major_alarm;
		item_ch.downloading <= rq.downloading;
		item_ch.now_seconds <= rq.now_seconds;
		do
			@(posedge clk);
		while (!item_ch.ready);
		resolve_request(rq, emits, res);
		if (emits)
			status_due.push_back(known ? want : res);
	endtask

	// only while idle: drain, let the pipeline empty, then write all three
	task automatic program_regs(input logic [3:0] tx, input logic [3:0] rx,
		input logic [15:0] to);
		cfg_idx_t              idx[3];
		logic [CFG_DATA_W-1:0] word[3];
		logic [31:0]           junk;
		item_ch.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		junk = $urandom();
		idx = '{CFG_TX_PORTS, CFG_RX_PORTS, CFG_HB_TIMEOUT};
		word = '{{junk[11:0], tx}, {junk[27:16], rx}, to};
		for (int i = 0; i < 3; i++) begin
			wr_en <= 1'b1;
			wr_index <= idx[i];
			wr_data <= word[i];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		cfg_tx = word[0][CNT_W-1:0];
		cfg_rx = word[1][CNT_W-1:0];
		cfg_hb_to = word[2];
	endtask

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] seen);
		if (seen !== want) begin
			fails++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, seen);
		end
	endfunction

	initial begin : result_sink
		int      stall;
		result_t due;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 12) : 0;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!res_ch.valid);
			if (status_due.size() == 0) begin
				fails++;
				$display("%0t: result with none expected, expected nothing got state %0d",
					$time, res_ch.radio_state);
			end else begin
				due = status_due.pop_front();
				check_field("radio_state", 8'(due.radio_state), 8'(res_ch.radio_state));
				check_field("state_changed", 8'(due.state_changed), 8'(res_ch.state_changed));
				check_field("shutdown_request_mask", due.shutdown_request_mask,
					res_ch.shutdown_request_mask);
				check_field("shutdown_done_mask", due.shutdown_done_mask,
					res_ch.shutdown_done_mask);
				check_field("clear_path_mask", due.clear_path_mask, res_ch.clear_path_mask);
				check_field("clear_common_alarms", 8'(due.clear_common_alarms),
					8'(res_ch.clear_common_alarms));
				check_field("reboot_request", 8'(due.reboot_request),
					8'(res_ch.reboot_request));
			end
		end
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_radio_fault_state_resolver_top: errors");
		$finish;
	end

	initial begin : stimulus
		dir_row_t rows[$];
		item_t    rq;
		int       ph_tx[6] = '{8, 0, 5, 15, 3, 8};
		int       ph_rx[6] = '{8, 3, 0, 15, 7, 8};
		int       ph_to[6] = '{65535, 0, 10, 1, 2, 0};
		int       sent;

		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = CFG_TX_PORTS;
		wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_SERVICE;
		item_ch.port = '0;
		item_ch.tx_shutdown_alarms = '0;
		item_ch.tx_degraded_alarms = '0;
		item_ch.vswr_alarms = '0;
		item_ch.rx_major_alarms = '0;
		item_ch.heartbeat_alarm = 1'b0;
		item_ch.radio_temp_major_alarm = 1'b0;
		item_ch.link_major_alarm = 1'b0;
		item_ch.downloading = 1'b0;
		item_ch.now_seconds = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: two transmit and two receive paths, 60 s heartbeat timeout
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_STANDBY, 1, 8'h00, 8'h00, 8'h00, 0, 0)});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_STANDBY, 0, 8'h00, 8'h00, 8'h00, 0, 0)});
		rows.push_back('{pack_req(OP_UNUSED, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1, 1, 1, 1, 32'hFFFFFFFF), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			0, 1, 1, 1, 32'h0), 1,
			status(ST_DOWNLOAD, 1, 8'h00, 8'h00, 8'h00, 0, 0)});
		// heartbeat start just before the counter wraps
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1, 1, 1, 0, 32'hFFFFFFFF), 1,
			status(ST_FAILED, 1, 8'h03, 8'h03, 8'h00, 0, 0)});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1, 1, 1, 0, 32'd60), 1,
			status(ST_FAILED, 0, 8'h03, 8'h03, 8'h00, 0, 1)});
		rows.push_back('{pack_req(OP_TX_ON, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		// port beyond the present paths still marks the flags as updated
		rows.push_back('{pack_req(OP_TX_ON, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1, 1, 1, 1, 32'hFFFFFFFF), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			1, 1, 1, 0, 32'd61), 1,
			status(ST_DEGRADED, 1, 8'h02, 8'h02, 8'h01, 1, 0)});
		rows.push_back('{pack_req(OP_TX_OFF, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_TX_OFF, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_STANDBY, 1, 8'h00, 8'h02, 8'h00, 0, 0)});
		rows.push_back('{pack_req(OP_TX_ON, 3'd1, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_NORMAL, 1, 8'h00, 8'h00, 8'h02, 1, 0)});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h01, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_DEGRADED, 1, 8'h00, 8'h00, 8'h00, 0, 0)});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h03,
			0, 0, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 1, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h01, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		// heartbeat timeout boundary: equal is not enough, one more second is
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			1, 0, 0, 0, 32'd100), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			1, 0, 0, 0, 32'd160), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			1, 0, 0, 0, 32'd161), 1,
			status(ST_FAILED, 0, 8'h03, 8'h03, 8'h00, 0, 1)});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 1, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_TX_ON, 3'd5, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 0, '0});
		rows.push_back('{pack_req(OP_SERVICE, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00,
			0, 0, 0, 0, 32'h0), 1,
			status(ST_NORMAL, 1, 8'h00, 8'h01, 8'h02, 1, 0)});

		foreach (rows[i])
			offer(rows[i].req, 1'b0, rows[i].known, rows[i].want);

		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 6)
				program_regs(4'(ph_tx[ph]), 4'(ph_rx[ph]), 16'(ph_to[ph]));
			else
				program_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					16'($urandom_range(0, 24)));
			tx_idle = (ph != 0) && $urandom_range(0, 2) != 0;
			rx_idle = (ph != 0) && $urandom_range(0, 2) != 0;
			sent = 0;
			while (sent < 95) begin
				rq = draw_request();
				offer(rq, ($urandom_range(0, 49) == 0) || (ph == 1 && sent == 40),
					1'b0, '0);
				if (rq.op != OP_UNUSED)
					sent++;
			end
		end

		item_ch.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("tb_radio_fault_state_resolver_top: clean");
		else
			$display("tb_radio_fault_state_resolver_top: errors");
		$finish;
	end

endmodule
